// ===== rtl/assert_macros.svh =====
// Concurrent assertion helpers, clocked on the rising edge, off while in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds.
`define TSSG_ASSERT(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check that a condition never occurs.
`define TSSG_ASSERT_NEVER(name, clk, rstn, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

// ===== rtl/tssg_pkg.sv =====
package tssg_pkg;

  localparam int unsigned COORD_W       = 5;
  localparam int unsigned COLOR_W       = 32;
  localparam int unsigned TILE_SIZE     = 32;
  localparam int unsigned FRAC_BITS_DEF = 16;

  localparam logic [COORD_W-1:0] COORD_MAX = COORD_W'(TILE_SIZE - 1);

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_DIV_SPLIT,
    CMD_SPLIT_TAKE,
    CMD_DIV_DOWN,
    CMD_INIT_DOWN,
    CMD_EMIT_DOWN,
    CMD_DIV_UP,
    CMD_INIT_UP,
    CMD_EMIT_UP,
    CMD_EMIT_FLAT
  } tssg_op_e;

  typedef struct packed {
    tssg_op_e op;
    logic     last;
  } tssg_cmd_t;

  typedef struct packed {
    logic flat;
    logic flat_bottom;
    logic flat_top;
    logic row_at_end;
    logic div_busy;
  } tssg_sts_t;

  function automatic logic [COORD_W-1:0] clamp_coord(input logic [COORD_W-1:0] v);
    clamp_coord = (v > COORD_MAX) ? COORD_MAX : v;
  endfunction

endpackage

// ===== rtl/tssg_tri_if.sv =====
interface tssg_tri_if;
  import tssg_pkg::*;

  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] vert_a_x;
  logic [COORD_W-1:0] vert_a_y;
  logic [COORD_W-1:0] vert_b_x;
  logic [COORD_W-1:0] vert_b_y;
  logic [COORD_W-1:0] vert_c_x;
  logic [COORD_W-1:0] vert_c_y;
  logic [COLOR_W-1:0] fill_color;

  modport source (
    output valid, vert_a_x, vert_a_y, vert_b_x, vert_b_y, vert_c_x, vert_c_y, fill_color,
    input  ready
  );

  modport sink (
    input  valid, vert_a_x, vert_a_y, vert_b_x, vert_b_y, vert_c_x, vert_c_y, fill_color,
    output ready
  );
endinterface

// ===== rtl/tssg_span_if.sv =====
interface tssg_span_if;
  import tssg_pkg::*;

  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] span_row;
  logic [COORD_W-1:0] span_from;
  logic [COORD_W-1:0] span_to;
  logic [COLOR_W-1:0] span_color;
  logic               last_span;

  modport source (
    output valid, span_row, span_from, span_to, span_color, last_span,
    input  ready
  );

  modport sink (
    input  valid, span_row, span_from, span_to, span_color, last_span,
    output ready
  );
endinterface

// ===== rtl/tssg_div.sv =====
module tssg_div #(
  parameter int unsigned W     = 21,
  parameter int unsigned DEN_W = 5
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [W-1:0]     num_a_i,
  input  logic [W-1:0]     num_b_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             busy_o,
  output logic [W-1:0]     quo_a_o,
  output logic [W-1:0]     quo_b_o,
  output logic [DEN_W-1:0] rem_a_o
);

  localparam int unsigned CNT_W = $clog2(W);

  logic [W-1:0]     qa_q, qb_q;
  logic [DEN_W-1:0] ra_q, rb_q, den_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;

  logic [DEN_W:0]   ta, tb;
  logic             ge_a, ge_b;
  logic [DEN_W:0]   sa, sb;

  assign ta   = {ra_q, qa_q[W-1]};
  assign tb   = {rb_q, qb_q[W-1]};
  assign ge_a = ta >= {1'b0, den_q};
  assign ge_b = tb >= {1'b0, den_q};
  assign sa   = ge_a ? (ta - {1'b0, den_q}) : ta;
  assign sb   = ge_b ? (tb - {1'b0, den_q}) : tb;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(W - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      qa_q  <= num_a_i;
      qb_q  <= num_b_i;
      ra_q  <= '0;
      rb_q  <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      qa_q <= {qa_q[W-2:0], ge_a};
      qb_q <= {qb_q[W-2:0], ge_b};
      ra_q <= sa[DEN_W-1:0];
      rb_q <= sb[DEN_W-1:0];
    end
  end

  assign busy_o  = busy_q;
  assign quo_a_o = qa_q;
  assign quo_b_o = qb_q;
  assign rem_a_o = ra_q;

endmodule

// ===== rtl/tssg_datapath.sv =====
module tssg_datapath #(
  parameter int unsigned FRAC_BITS = tssg_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  tssg_pkg::tssg_cmd_t          cmd_i,
  output tssg_pkg::tssg_sts_t          sts_o,
  input  logic [tssg_pkg::COORD_W-1:0] vert_a_x_i,
  input  logic [tssg_pkg::COORD_W-1:0] vert_a_y_i,
  input  logic [tssg_pkg::COORD_W-1:0] vert_b_x_i,
  input  logic [tssg_pkg::COORD_W-1:0] vert_b_y_i,
  input  logic [tssg_pkg::COORD_W-1:0] vert_c_x_i,
  input  logic [tssg_pkg::COORD_W-1:0] vert_c_y_i,
  input  logic [tssg_pkg::COLOR_W-1:0] fill_color_i,
  output logic [tssg_pkg::COORD_W-1:0] span_row_o,
  output logic [tssg_pkg::COORD_W-1:0] span_from_o,
  output logic [tssg_pkg::COORD_W-1:0] span_to_o,
  output logic [tssg_pkg::COLOR_W-1:0] span_color_o,
  output logic                         last_span_o
);
  import tssg_pkg::*;

  localparam int unsigned DIV_W  = FRAC_BITS + COORD_W;
  localparam int unsigned SL_W   = DIV_W + 1;
  localparam int unsigned INT_W  = COORD_W + 3;
  localparam int unsigned ACC_W  = FRAC_BITS + INT_W;
  localparam int unsigned PROD_W = 2 * COORD_W;
  localparam int unsigned MX_W   = COORD_W + 2;

  function automatic logic [COORD_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                  input logic [COORD_W-1:0] b);
    abs_diff = (a >= b) ? (a - b) : (b - a);
  endfunction

  function automatic logic [COORD_W-1:0] to_column(input logic signed [ACC_W-1:0] a);
    logic [INT_W-1:0] ip;
    ip = a[ACC_W-1:FRAC_BITS];
    if (a[ACC_W-1]) begin
      to_column = '0;
    end else if ((ip[INT_W-1:COORD_W] != '0) || (ip[COORD_W-1:0] > COORD_MAX)) begin
      to_column = COORD_MAX;
    end else begin
      to_column = ip[COORD_W-1:0];
    end
  endfunction

  function automatic logic signed [SL_W-1:0] signed_quo(input logic [DIV_W-1:0] q,
                                                        input logic neg);
    logic signed [SL_W-1:0] s;
    s = $signed({1'b0, q});
    signed_quo = neg ? -s : s;
  endfunction

  function automatic logic signed [ACC_W-1:0] ext_slope(input logic signed [SL_W-1:0] s);
    ext_slope = $signed({{(ACC_W-SL_W){s[SL_W-1]}}, s});
  endfunction

  function automatic logic signed [ACC_W-1:0] col_acc(input logic [COORD_W-1:0] x);
    col_acc = $signed({{(INT_W-COORD_W){1'b0}}, x, {FRAC_BITS{1'b0}}});
  endfunction

  // Vertex registers, sorted by row
  logic [COORD_W-1:0] x0_q, y0_q, x1_q, y1_q, x2_q, y2_q, mx_q;
  logic [COLOR_W-1:0] color_q;
  logic signed [SL_W-1:0]  slope_s_q, slope_e_q;
  logic signed [ACC_W-1:0] acc_s_q, acc_e_q;
  logic [COORD_W-1:0] row_q, end_row_q;
  logic               neg_a_q, neg_b_q;
  logic [COORD_W-1:0] span_row_q, span_from_q, span_to_q;
  logic [COLOR_W-1:0] span_color_q;
  logic               span_last_q;

  logic [COORD_W-1:0] sx0, sy0, sx1, sy1, sx2, sy2, tx, ty;

  always_comb begin
    tx  = '0;
    ty  = '0;
    sx0 = clamp_coord(vert_a_x_i);
    sy0 = clamp_coord(vert_a_y_i);
    sx1 = clamp_coord(vert_b_x_i);
    sy1 = clamp_coord(vert_b_y_i);
    sx2 = clamp_coord(vert_c_x_i);
    sy2 = clamp_coord(vert_c_y_i);
    if (sy0 > sy1) begin
      tx = sx0; ty = sy0; sx0 = sx1; sy0 = sy1; sx1 = tx; sy1 = ty;
    end
    if (sy1 > sy2) begin
      tx = sx1; ty = sy1; sx1 = sx2; sy1 = sy2; sx2 = tx; sy2 = ty;
    end
    if (sy0 > sy1) begin
      tx = sx0; ty = sy0; sx0 = sx1; sy0 = sy1; sx1 = tx; sy1 = ty;
    end
  end

  // Divider operands
  logic               div_start;
  logic [DIV_W-1:0]   num_a, num_b;
  logic [COORD_W-1:0] den;
  logic               neg_a, neg_b;
  logic [COORD_W-1:0] up_sx, up_ex;
  logic [PROD_W-1:0]  split_prod;
  logic               div_busy;
  logic [DIV_W-1:0]   quo_a, quo_b;
  logic [COORD_W-1:0] rem_a;

  assign up_sx      = sts_o.flat_top ? x0_q : x1_q;
  assign up_ex      = sts_o.flat_top ? x1_q : mx_q;
  assign split_prod = abs_diff(x2_q, x0_q) * (y1_q - y0_q);

  always_comb begin
    div_start = 1'b0;
    num_a     = '0;
    num_b     = '0;
    den       = '0;
    neg_a     = 1'b0;
    neg_b     = 1'b0;
    case (cmd_i.op)
      CMD_DIV_SPLIT: begin
        div_start = 1'b1;
        num_a     = {{(DIV_W-PROD_W){1'b0}}, split_prod};
        den       = y2_q - y0_q;
        neg_a     = x2_q < x0_q;
      end
      CMD_DIV_DOWN: begin
        div_start = 1'b1;
        num_a     = {abs_diff(x1_q, x0_q), {FRAC_BITS{1'b0}}};
        num_b     = {abs_diff(mx_q, x0_q), {FRAC_BITS{1'b0}}};
        den       = y1_q - y0_q;
        neg_a     = x1_q < x0_q;
        neg_b     = mx_q < x0_q;
      end
      CMD_DIV_UP: begin
        div_start = 1'b1;
        num_a     = {abs_diff(x2_q, up_sx), {FRAC_BITS{1'b0}}};
        num_b     = {abs_diff(x2_q, up_ex), {FRAC_BITS{1'b0}}};
        den       = y2_q - y1_q;
        neg_a     = x2_q < up_sx;
        neg_b     = x2_q < up_ex;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  tssg_div #(
    .W     (DIV_W),
    .DEN_W (COORD_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_a_i (num_a),
    .num_b_i (num_b),
    .den_i   (den),
    .busy_o  (div_busy),
    .quo_a_o (quo_a),
    .quo_b_o (quo_b),
    .rem_a_o (rem_a)
  );

  // Split column: floor of the signed quotient
  logic [MX_W-1:0]    split_q, split_mag, mx_full;
  logic [COORD_W-1:0] flat_lo, flat_hi;

  assign split_mag = MX_W'(quo_a[COORD_W-1:0]);
  assign split_q   = neg_a_q ? (~(split_mag + MX_W'(rem_a != '0)) + 1'b1) : split_mag;
  assign mx_full   = {2'b00, x0_q} + split_q;

  always_comb begin
    flat_lo = x0_q;
    flat_hi = x0_q;
    if (x1_q < flat_lo) flat_lo = x1_q;
    if (x2_q < flat_lo) flat_lo = x2_q;
    if (x1_q > flat_hi) flat_hi = x1_q;
    if (x2_q > flat_hi) flat_hi = x2_q;
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      CMD_LOAD: begin
        x0_q    <= sx0;
        y0_q    <= sy0;
        x1_q    <= sx1;
        y1_q    <= sy1;
        x2_q    <= sx2;
        y2_q    <= sy2;
        mx_q    <= sx2;
        color_q <= fill_color_i;
      end
      CMD_DIV_SPLIT, CMD_DIV_DOWN, CMD_DIV_UP: begin
        neg_a_q <= neg_a;
        neg_b_q <= neg_b;
      end
      CMD_SPLIT_TAKE: begin
        mx_q <= mx_full[COORD_W-1:0];
      end
      CMD_INIT_DOWN: begin
        slope_s_q <= signed_quo(quo_a, neg_a_q);
        slope_e_q <= signed_quo(quo_b, neg_b_q);
        acc_s_q   <= col_acc(x0_q);
        acc_e_q   <= col_acc(x0_q);
        row_q     <= y0_q;
        end_row_q <= y1_q;
      end
      CMD_INIT_UP: begin
        slope_s_q <= signed_quo(quo_a, neg_a_q);
        slope_e_q <= signed_quo(quo_b, neg_b_q);
        acc_s_q   <= col_acc(x2_q);
        acc_e_q   <= col_acc(x2_q);
        row_q     <= y2_q;
        end_row_q <= y1_q;
      end
      CMD_EMIT_DOWN: begin
        span_row_q   <= row_q;
        span_from_q  <= to_column(acc_s_q);
        span_to_q    <= to_column(acc_e_q);
        span_color_q <= color_q;
        span_last_q  <= cmd_i.last;
        acc_s_q      <= acc_s_q + ext_slope(slope_s_q);
        acc_e_q      <= acc_e_q + ext_slope(slope_e_q);
        row_q        <= row_q + 1'b1;
      end
      CMD_EMIT_UP: begin
        span_row_q   <= row_q;
        span_from_q  <= to_column(acc_s_q);
        span_to_q    <= to_column(acc_e_q);
        span_color_q <= color_q;
        span_last_q  <= cmd_i.last;
        acc_s_q      <= acc_s_q - ext_slope(slope_s_q);
        acc_e_q      <= acc_e_q - ext_slope(slope_e_q);
        row_q        <= row_q - 1'b1;
      end
      CMD_EMIT_FLAT: begin
        span_row_q   <= y0_q;
        span_from_q  <= flat_lo;
        span_to_q    <= flat_hi;
        span_color_q <= color_q;
        span_last_q  <= cmd_i.last;
      end
      default: begin
        row_q <= row_q;
      end
    endcase
  end

  assign sts_o.flat        = y0_q == y2_q;
  assign sts_o.flat_bottom = y1_q == y2_q;
  assign sts_o.flat_top    = y0_q == y1_q;
  assign sts_o.row_at_end  = row_q == end_row_q;
  assign sts_o.div_busy    = div_busy;

  assign span_row_o   = span_row_q;
  assign span_from_o  = span_from_q;
  assign span_to_o    = span_to_q;
  assign span_color_o = span_color_q;
  assign last_span_o  = span_last_q;

endmodule

// ===== rtl/tssg_ctrl.sv =====
module tssg_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                tri_valid_i,
  output logic                tri_ready_o,
  input  logic                span_ready_i,
  output logic                span_valid_o,
  input  tssg_pkg::tssg_sts_t sts_i,
  output tssg_pkg::tssg_cmd_t cmd_o
);
  import tssg_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLASS,
    S_SPLIT_WAIT,
    S_SPLIT_TAKE,
    S_DOWN_START,
    S_DOWN_WAIT,
    S_DOWN_EMIT,
    S_UP_START,
    S_UP_WAIT,
    S_UP_EMIT,
    S_FLAT
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;
  logic        emit;

  assign out_free = !out_valid_q || span_ready_i;
  assign emit     = (cmd_o.op == CMD_EMIT_DOWN) || (cmd_o.op == CMD_EMIT_UP) ||
                    (cmd_o.op == CMD_EMIT_FLAT);

  always_comb begin
    state_d     = state_q;
    cmd_o.op    = CMD_NONE;
    cmd_o.last  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (tri_valid_i) begin
          cmd_o.op = CMD_LOAD;
          state_d  = S_CLASS;
        end
      end
      S_CLASS: begin
        if (sts_i.flat) begin
          state_d = S_FLAT;
        end else if (sts_i.flat_bottom) begin
          state_d = S_DOWN_START;
        end else if (sts_i.flat_top) begin
          state_d = S_UP_START;
        end else begin
          cmd_o.op = CMD_DIV_SPLIT;
          state_d  = S_SPLIT_WAIT;
        end
      end
      S_SPLIT_WAIT: begin
        if (!sts_i.div_busy) state_d = S_SPLIT_TAKE;
      end
      S_SPLIT_TAKE: begin
        cmd_o.op = CMD_SPLIT_TAKE;
        state_d  = S_DOWN_START;
      end
      S_DOWN_START: begin
        cmd_o.op = CMD_DIV_DOWN;
        state_d  = S_DOWN_WAIT;
      end
      S_DOWN_WAIT: begin
        if (!sts_i.div_busy) begin
          cmd_o.op = CMD_INIT_DOWN;
          state_d  = S_DOWN_EMIT;
        end
      end
      S_DOWN_EMIT: begin
        if (out_free) begin
          cmd_o.op   = CMD_EMIT_DOWN;
          cmd_o.last = sts_i.flat_bottom && sts_i.row_at_end;
          if (sts_i.row_at_end) state_d = sts_i.flat_bottom ? S_IDLE : S_UP_START;
        end
      end
      S_UP_START: begin
        cmd_o.op = CMD_DIV_UP;
        state_d  = S_UP_WAIT;
      end
      S_UP_WAIT: begin
        if (!sts_i.div_busy) begin
          cmd_o.op = CMD_INIT_UP;
          state_d  = S_UP_EMIT;
        end
      end
      S_UP_EMIT: begin
        if (out_free) begin
          cmd_o.op   = CMD_EMIT_UP;
          cmd_o.last = sts_i.row_at_end;
          if (sts_i.row_at_end) state_d = S_IDLE;
        end
      end
      S_FLAT: begin
        if (out_free) begin
          cmd_o.op   = CMD_EMIT_FLAT;
          cmd_o.last = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (span_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign tri_ready_o  = state_q == S_IDLE;
  assign span_valid_o = out_valid_q;

endmodule

// ===== rtl/triangle_scanline_span_generator.sv =====
// Flow: a flat triangle emits its span directly; a flat-top or flat-bottom one runs the
// slope divider once before its first span, a general one first runs it for the split column.
// One triangle at a time: intake opens again only once its last span is emitted, and
// the spans of each triangle wait on the runs of the bit-serial slope divider.
// Reset: asynchronous active low; clears the sequencer, divider and output valid.
`include "assert_macros.svh"

module triangle_scanline_span_generator #(
  parameter int unsigned FRAC_BITS = tssg_pkg::FRAC_BITS_DEF
) (
  input logic        clk_i,
  input logic        rst_ni,
  tssg_tri_if.sink   tri_i,
  tssg_span_if.source span_o
);
  import tssg_pkg::*;

  tssg_cmd_t cmd;
  tssg_sts_t sts;

  tssg_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tri_valid_i  (tri_i.valid),
    .tri_ready_o  (tri_i.ready),
    .span_ready_i (span_o.ready),
    .span_valid_o (span_o.valid),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  tssg_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .vert_a_x_i   (tri_i.vert_a_x),
    .vert_a_y_i   (tri_i.vert_a_y),
    .vert_b_x_i   (tri_i.vert_b_x),
    .vert_b_y_i   (tri_i.vert_b_y),
    .vert_c_x_i   (tri_i.vert_c_x),
    .vert_c_y_i   (tri_i.vert_c_y),
    .fill_color_i (tri_i.fill_color),
    .span_row_o   (span_o.span_row),
    .span_from_o  (span_o.span_from),
    .span_to_o    (span_o.span_to),
    .span_color_o (span_o.span_color),
    .last_span_o  (span_o.last_span)
  );

  `TSSG_ASSERT(a_last_frees_intake, clk_i, rst_ni, cmd.last |=> tri_i.ready, "last span did not return to intake")
  `TSSG_ASSERT_NEVER(a_busy_no_intake, clk_i, rst_ni, sts.div_busy && tri_i.ready, "intake open while dividing")
  `TSSG_ASSERT_NEVER(a_busy_no_emit, clk_i, rst_ni, sts.div_busy && (cmd.op == CMD_EMIT_DOWN || cmd.op == CMD_EMIT_UP || cmd.op == CMD_EMIT_FLAT), "span emitted while dividing")

endmodule
